FILE: design/base64_stream_encoder_macros.svh
// Assertion macros shared by the encoder modules.
// The synthesis variants expand to nothing.
`ifndef BASE64_STREAM_ENCODER_MACROS_SVH
`define BASE64_STREAM_ENCODER_MACROS_SVH

`ifndef SYNTHESIS

`define B64E_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("base64 encoder assertion failed");

`define B64E_ASSERT_NEVER(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("base64 encoder forbidden condition seen");

`else

`define B64E_ASSERT(label, clk, rst_n, prop)

`define B64E_ASSERT_NEVER(label, clk, rst_n, expr)

`endif

`endif

FILE: design/b64e_pkg.sv
package b64e_pkg;

  localparam int unsigned CharW    = 8;
  localparam int unsigned SextetW  = 6;
  localparam int unsigned NumSlots = 4;
  localparam int unsigned SlotIdxW = 2;

  localparam logic [CharW-1:0] PadChar   = 8'h3D;
  localparam logic [CharW-1:0] PlusChar  = 8'h2B;
  localparam logic [CharW-1:0] SlashChar = 8'h2F;
  localparam logic [CharW-1:0] UpperBase = 8'h41;
  localparam logic [CharW-1:0] LowerBase = 8'h47;  // 'a' less 26
  localparam logic [CharW-1:0] DigitBase = 8'hFC;  // '0' less 52, modulo 256

  // One queued job: the characters that one input byte produces.
  typedef struct packed {
    logic [NumSlots-1:0][CharW-1:0] chars;
    logic [SlotIdxW-1:0]            cnt_m1;
    logic                           last;
  } b64e_job_t;

  // Maps a sextet onto the standard alphabet.
  function automatic logic [CharW-1:0] b64_char(input logic [SextetW-1:0] v);
    logic [CharW-1:0] wide;
    logic [CharW-1:0] ch;
    wide = {2'b00, v};
    if (v < 6'd26) begin
      ch = UpperBase + wide;
    end else if (v < 6'd52) begin
      ch = LowerBase + wide;
    end else if (v < 6'd62) begin
      ch = DigitBase + wide;
    end else if (v == 6'd62) begin
      ch = PlusChar;
    end else begin
      ch = SlashChar;
    end
    return ch;
  endfunction

endpackage

FILE: design/b64e_front.sv
module b64e_front
  import b64e_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  logic [CharW-1:0] data_byte_i,
  input  logic             last_byte_i,
  input  logic             queue_full_i,
  output logic             push_o,
  output b64e_job_t        job_o
);

  typedef enum logic [1:0] {
    PH_ZERO,
    PH_ONE,
    PH_TWO
  } b64e_phase_e;

  b64e_phase_e   phase_q, phase_d;
  logic [3:0]    left_q, left_d;
  logic [SextetW-1:0] s0, s1;

  assign ready_o = !queue_full_i;
  assign push_o  = valid_i && ready_o;

  always_comb begin
    s0      = '0;
    s1      = '0;
    phase_d = PH_ZERO;
    left_d  = '0;
    job_o   = '0;
    unique case (phase_q)
      PH_ONE: begin
        s0           = {left_q[1:0], data_byte_i[7:4]};
        phase_d      = PH_TWO;
        left_d       = data_byte_i[3:0];
        job_o.cnt_m1 = 2'd0;
      end
      PH_TWO: begin
        s0           = {left_q, data_byte_i[7:6]};
        s1           = data_byte_i[5:0];
        phase_d      = PH_ZERO;
        left_d       = '0;
        job_o.cnt_m1 = 2'd1;
      end
      default: begin
        s0           = data_byte_i[7:2];
        phase_d      = PH_ONE;
        left_d       = {2'b00, data_byte_i[1:0]};
        job_o.cnt_m1 = 2'd0;
      end
    endcase
    job_o.chars[0] = b64_char(s0);
    job_o.chars[1] = b64_char(s1);
    job_o.last     = last_byte_i;
    if (last_byte_i) begin
      // Flush the leftover bits, zero-filled, then pad to a full quad.
      if (phase_d == PH_ONE) begin
        job_o.chars[1] = b64_char({left_d[1:0], 4'b0000});
        job_o.chars[2] = PadChar;
        job_o.chars[3] = PadChar;
        job_o.cnt_m1   = 2'd3;
      end else if (phase_d == PH_TWO) begin
        job_o.chars[1] = b64_char({left_d, 2'b00});
        job_o.chars[2] = PadChar;
        job_o.cnt_m1   = 2'd2;
      end
      phase_d = PH_ZERO;
      left_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_ZERO;
      left_q  <= '0;
    end else if (push_o) begin
      phase_q <= phase_d;
      left_q  <= left_d;
    end
  end

endmodule

FILE: design/b64e_fifo.sv
`include "base64_stream_encoder_macros.svh"

module b64e_fifo
  import b64e_pkg::*;
#(
  parameter int unsigned Depth = 2
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  b64e_job_t data_i,
  output logic      full_o,
  input  logic      pop_i,
  output logic      not_empty_o,
  output b64e_job_t data_o
);

  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  b64e_job_t        mem_q [Depth];
  logic [AddrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  count_q;

  assign full_o      = (count_q == CntW'(Depth));
  assign not_empty_o = (count_q != '0);
  assign data_o      = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == AddrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == AddrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  `B64E_ASSERT_NEVER(a_no_overflow, clk_i, rst_ni, push_i && full_o)
  `B64E_ASSERT_NEVER(a_no_underflow, clk_i, rst_ni, pop_i && !not_empty_o)

endmodule

FILE: design/b64e_back.sv
`include "base64_stream_encoder_macros.svh"

module b64e_back
  import b64e_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             job_valid_i,
  input  b64e_job_t        job_i,
  output logic             job_pop_o,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [CharW-1:0] m_axis_tdata,
  output logic             m_axis_tlast
);

  b64e_job_t           job_q;
  logic                job_valid_q;
  logic [SlotIdxW-1:0] idx_q;
  logic                out_valid_q;
  logic [CharW-1:0]    out_char_q;
  logic                out_last_q;
  logic                load;
  logic                final_slot;

  assign load       = job_valid_q && (!out_valid_q || m_axis_tready);
  assign final_slot = (idx_q == job_q.cnt_m1);
  assign job_pop_o  = job_valid_i && (!job_valid_q || (load && final_slot));

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_char_q;
  assign m_axis_tlast  = out_last_q;

  always_ff @(posedge clk_i) begin
    if (job_pop_o) begin
      job_q <= job_i;
    end
    if (load) begin
      out_char_q <= job_q.chars[idx_q];
      out_last_q <= job_q.last && final_slot;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_valid_q <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (job_pop_o) begin
        job_valid_q <= 1'b1;
        idx_q       <= '0;
      end else if (load) begin
        if (final_slot) begin
          job_valid_q <= 1'b0;
        end
        idx_q <= idx_q + 1'b1;
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // A byte that does not end the message gives one or two characters;
  // a closing byte always gives at least two.
  `B64E_ASSERT(a_job_shape, clk_i, rst_ni,
               job_pop_o |-> (job_i.last ? (job_i.cnt_m1 != '0) : (job_i.cnt_m1 <= 2'd1)))
  `B64E_ASSERT_NEVER(a_idx_in_range, clk_i, rst_ni, job_valid_q && (idx_q > job_q.cnt_m1))

endmodule

FILE: design/base64_stream_encoder.sv
// A taken byte passes through the job queue, the job register and the output register.
// Throughput: one character per cycle at the output register while m_axis_tready is high,
// so a byte gives one to four characters (four characters for every three bytes of a long
// message); the single-character output port sets this rate.
// Input bytes are taken every cycle while the job queue between front and back has room.
// Reset (rst_ni low, asynchronous) restarts the group phase, empties the queue and drops tvalid.
module base64_stream_encoder
  import b64e_pkg::*;
#(
  parameter int unsigned QueueDepth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  // Input bytes.
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [CharW-1:0] s_axis_tdata,   // [7:0] data_byte
  input  logic             s_axis_tlast,   // last_byte
  // Encoded characters.
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [CharW-1:0] m_axis_tdata,   // [7:0] out_char
  output logic             m_axis_tlast    // last_char
);

  // The front end turns each accepted byte into a job holding all of
  // the characters it produces, including the flush character and the
  // padding when the byte closes the message.
  b64e_job_t push_job;
  b64e_job_t head_job;
  logic      push;
  logic      pop;
  logic      queue_full;
  logic      queue_not_empty;

  b64e_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (s_axis_tvalid),
    .ready_o      (s_axis_tready),
    .data_byte_i  (s_axis_tdata),
    .last_byte_i  (s_axis_tlast),
    .queue_full_i (queue_full),
    .push_o       (push),
    .job_o        (push_job)
  );

  // The short job queue lets the input side keep taking bytes while the
  // output side is still working through a longer job or is stalled.
  b64e_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .data_i      (push_job),
    .full_o      (queue_full),
    .pop_i       (pop),
    .not_empty_o (queue_not_empty),
    .data_o      (head_job)
  );

  // The back end issues the characters of each job one per cycle while m_axis_tready
  // allows, through a registered output stage, and marks the final one.
  b64e_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .job_valid_i   (queue_not_empty),
    .job_i         (head_job),
    .job_pop_o     (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

FILE: tb/sv/tb_base64_stream_encoder.sv
module tb_base64_stream_encoder;
  import b64e_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Position of the next byte within its three-byte group.
  localparam logic [1:0] PhaseFirst  = 2'd0;
  localparam logic [1:0] PhaseSecond = 2'd1;
  localparam logic [1:0] PhaseThird  = 2'd2;

  // The standard alphabet; character 0 sits in the top byte of the vector.
  localparam logic [511:0] B64Alphabet =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  localparam int unsigned RandomItems  = 120;
  localparam int unsigned HoldCycles   = 300;
  localparam int unsigned DrainCycles  = 20;
  localparam int unsigned MaxReported  = 10;

  typedef struct packed {
    logic [CharW-1:0] data;
    logic             last;
  } byte_item_t;

  typedef struct packed {
    logic [CharW-1:0] ch;
    logic             last;
  } char_item_t;

  logic             clk_i         = 1'b0;
  logic             rst_ni        = 1'b0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [CharW-1:0] s_axis_tdata  = '0;
  logic             s_axis_tlast  = 1'b0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [CharW-1:0] m_axis_tdata;
  logic             m_axis_tlast;

  base64_stream_encoder dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  // Message bytes still to be offered, and characters still owed by the block.
  byte_item_t  pending_bytes[$];
  char_item_t  expected_chars[$];

  // The encoder state as the predictor sees it.
  logic [1:0]  enc_phase = PhaseFirst;
  logic [3:0]  enc_carry = 4'd0;

  int unsigned mismatch_count = 0;
  int unsigned bytes_taken    = 0;
  logic        byte_taken     = 1'b0;
  logic        rx_hold        = 1'b0;

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  function automatic logic [CharW-1:0] sextet_char(input logic [5:0] v);
    return B64Alphabet[8*(63-int'(v)) +: 8];
  endfunction

  // Works out the characters that one accepted byte produces and queues them.
  // Data characters come first; on the last byte of a message the leftover bits
  // follow as one zero-filled character, then '=' padding up to four per group.
  task automatic predict_chars(input logic [CharW-1:0] b, input logic lst);
    logic [CharW-1:0] chars[4];
    int               n;
    char_item_t       item;
    n = 0;
    case (enc_phase)
      PhaseSecond: begin
        chars[n] = sextet_char({enc_carry[1:0], b[7:4]}); n++;
        enc_carry = b[3:0];
        enc_phase = PhaseThird;
      end
      PhaseThird: begin
        chars[n] = sextet_char({enc_carry, b[7:6]}); n++;
        chars[n] = sextet_char(b[5:0]); n++;
        enc_carry = 4'd0;
        enc_phase = PhaseFirst;
      end
      default: begin
        // A phase of three cannot arise; it would behave as the first position.
        chars[n] = sextet_char(b[7:2]); n++;
        enc_carry = {2'b00, b[1:0]};
        enc_phase = PhaseSecond;
      end
    endcase
    if (lst) begin
      if (enc_phase == PhaseSecond) begin
        chars[n] = sextet_char({enc_carry[1:0], 4'b0000}); n++;
        chars[n] = PadChar; n++;
        chars[n] = PadChar; n++;
      end else if (enc_phase == PhaseThird) begin
        chars[n] = sextet_char({enc_carry, 2'b00}); n++;
        chars[n] = PadChar; n++;
      end
      // The end of a message returns the encoder to its reset state.
      enc_phase = PhaseFirst;
      enc_carry = 4'd0;
    end
    for (int i = 0; i < n; i++) begin
      item.ch   = chars[i];
      item.last = lst && (i == n - 1);
      expected_chars = {expected_chars, item};
    end
  endtask

  task automatic report_mismatch(input string what, input char_item_t want);
    mismatch_count++;
    if (mismatch_count <= MaxReported) begin
      $display("%0t: %s: expected char 0x%02h last %0b, got char 0x%02h last %0b",
               $realtime, what, want.ch, want.last, m_axis_tdata, m_axis_tlast);
    end
  endtask

  task automatic add_message(input logic [CharW-1:0] msg[$]);
    byte_item_t item;
    for (int i = 0; i < msg.size(); i++) begin
      item.data = msg[i];
      item.last = (i == msg.size() - 1);
      pending_bytes = {pending_bytes, item};
    end
  endtask

  // Monitor: both handshakes are sampled at the rising edge. Outputs of the block
  // change by nonblocking update after the edge, so the values read here are the
  // ones that the edge itself saw.
  always @(posedge clk_i) begin
    char_item_t want;
    byte_taken <= rst_ni && s_axis_tvalid && s_axis_tready;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_chars(s_axis_tdata, s_axis_tlast);
        bytes_taken++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_chars.size() == 0) begin
          want = '0;
          report_mismatch("character with none expected", want);
        end else begin
          want = expected_chars.pop_front();
          if (m_axis_tdata !== want.ch || m_axis_tlast !== want.last) begin
            report_mismatch("character mismatch", want);
          end
        end
      end
    end
  end

  // Driver: the sender works in bursts of random length separated by random gaps.
  // An item that is on offer stays put until the block takes it.
  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;

  always @(negedge clk_i) begin
    byte_item_t item;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (s_axis_tvalid && !byte_taken) begin
      // Still waiting for the handshake; hold the item.
    end else if (gap_left != 0) begin
      gap_left--;
      s_axis_tvalid <= 1'b0;
    end else if (pending_bytes.size() != 0) begin
      item = pending_bytes.pop_front();
      s_axis_tvalid <= 1'b1;
      s_axis_tdata  <= item.data;
      s_axis_tlast  <= item.last;
      if (burst_left != 0) begin
        burst_left--;
      end
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 16);
        // Half the gaps are empty, giving long stretches with no idling.
        gap_left = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 6);
      end
    end else begin
      s_axis_tvalid <= 1'b0;
    end
  end

  // Receiver: ready follows a rotating stall pattern that is redrawn during the run.
  // Some patterns never stall, some stall now and then, some mostly.
  logic [15:0] rx_pattern = 16'hFFFF;
  int unsigned rx_cycles  = 0;

  always @(negedge clk_i) begin
    if (rx_cycles % 48 == 0) begin
      case ($urandom_range(0, 3))
        0:       rx_pattern = 16'hFFFF;
        1:       rx_pattern = 16'($urandom()) | 16'($urandom());
        2:       rx_pattern = 16'($urandom());
        default: rx_pattern = 16'($urandom()) & 16'($urandom());
      endcase
      if (rx_pattern == 16'h0000) begin
        rx_pattern = 16'h0001;
      end
    end
    rx_cycles++;
    m_axis_tready <= rst_ni && !rx_hold && rx_pattern[0];
    rx_pattern = {rx_pattern[0], rx_pattern[15:1]};
  end

  // Back-pressure: once traffic is flowing the receiver holds off for a long
  // stretch while the sender keeps offering, so the job queue fills and the
  // block has to drop s_axis_tready.
  initial begin
    while (bytes_taken < 30) @(posedge clk_i);
    rx_hold = 1'b1;
    repeat (HoldCycles) @(posedge clk_i);
    rx_hold = 1'b0;
  end

  // Stimulus and end of run.
  initial begin
    logic [CharW-1:0] msg[$];
    int unsigned      len;

    // Directed messages: all-zero and all-one bytes, each group length with
    // its own padding, the two punctuation characters and a message that
    // runs past one group.
    msg = '{8'h00};                      add_message(msg);
    msg = '{8'hFF};                      add_message(msg);
    msg = '{8'hFF, 8'hFF};               add_message(msg);
    msg = '{8'hFF, 8'hFF, 8'hFF};        add_message(msg);
    msg = '{8'h00, 8'h00, 8'h00};        add_message(msg);
    msg = '{8'hFB, 8'hEF, 8'hBE};        add_message(msg);
    msg = '{8'h4D, 8'h61, 8'h6E, 8'h2E, 8'h2E}; add_message(msg);

    // Random messages, mostly short so that every padding case comes often,
    // with the occasional longer one.
    while (pending_bytes.size() < RandomItems) begin
      if ($urandom_range(0, 7) == 0) begin
        len = $urandom_range(7, 20);
      end else begin
        len = $urandom_range(1, 6);
      end
      msg.delete();
      for (int i = 0; i < len; i++) begin
        msg = {msg, 8'($urandom())};
      end
      add_message(msg);
    end

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Wait until every byte has been taken, then until every character is in.
    while (pending_bytes.size() != 0 || s_axis_tvalid) @(posedge clk_i);
    while (expected_chars.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (expected_chars.size() != 0) begin
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #400us;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

FILE: files.f
+incdir+design
design/b64e_pkg.sv
design/b64e_front.sv
design/b64e_fifo.sv
design/b64e_back.sv
design/base64_stream_encoder.sv
tb/sv/tb_base64_stream_encoder.sv
